// File: rtl/ivms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivms_pkg
// Shared types, constants and helpers for the image version marker scanner.
// ----------------------------------------------------------------------------
package ivms_pkg;

  localparam int CAPTURE_BYTES = 32;
  localparam int PART_BITS     = 16;
  localparam int COUNT_W       = $clog2(CAPTURE_BYTES);
  localparam int RUN_W         = 16;
  localparam int CMP_W         = (PART_BITS > RUN_W) ? PART_BITS : RUN_W;

  localparam int TAG_LEN = 7;
  localparam int TAG_W   = 3;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LO_V = 8'h76;
  localparam logic [7:0] CH_UP_V = 8'h56;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MAJOR = 2'd0;
  localparam logic [1:0] REG_MINOR = 2'd1;
  localparam logic [1:0] REG_PATCH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       image_end;
  } ivms_in_t;

  typedef struct packed {
    logic        marker_found;
    logic        version_valid;
    logic        image_older;
    logic [15:0] image_major;
    logic [15:0] image_minor;
    logic [15:0] image_patch;
    logic        verdict_ready;
  } ivms_out_t;

  typedef struct packed {
    logic [RUN_W-1:0] major;
    logic [RUN_W-1:0] minor;
    logic [RUN_W-1:0] patch;
  } ivms_run_t;

  // marker characters, in match order
  function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h53;
      3'd1: ch = 8'h51;
      3'd2: ch = 8'h57;
      3'd3: ch = 8'h56;
      3'd4: ch = 8'h45;
      3'd5: ch = 8'h52;
      3'd6: ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/ivms_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivms_cfg
// APB register file holding the running version numbers.
// ----------------------------------------------------------------------------
module ivms_cfg
  import ivms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output ivms_run_t          run
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAJOR: run.major <= pwdata[RUN_W-1:0];
        REG_MINOR: run.minor <= pwdata[RUN_W-1:0];
        REG_PATCH: run.patch <= pwdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAJOR: prdata = PDATA_W'(run.major);
      REG_MINOR: prdata = PDATA_W'(run.minor);
      REG_PATCH: prdata = PDATA_W'(run.patch);
      default:   prdata = '0;
    endcase
  end

endmodule

// File: rtl/ivms_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivms_scan
// Marker matcher, capture/parse state and version compare for one byte.
// ----------------------------------------------------------------------------
module ivms_scan
  import ivms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  ivms_in_t  item,
  input  ivms_run_t run,
  output ivms_out_t res
);

  localparam logic [PART_BITS-1:0] PART_MAX = '1;
  localparam int                   PROD_W   = PART_BITS + 4;

  typedef struct packed {
    logic [TAG_W-1:0]                tag;
    logic                            capturing;
    logic                            found;
    logic [COUNT_W-1:0]              count;
    logic [1:0]                      part_idx;
    logic                            digit_seen;
    logic                            bad;
    logic                            stopped;
    logic [2:0][PART_BITS-1:0]       parts;
  } scan_state_t;

  scan_state_t st;
  scan_state_t base;
  scan_state_t st_next;

  logic [7:0]            c;
  logic                  first;
  logic                  is_digit;
  logic                  complete;
  logic                  complete_next;
  logic [PART_BITS-1:0]  cur_part;
  logic [PROD_W-1:0]     prod;
  logic [PART_BITS-1:0]  sat_part;
  logic                  valid;
  logic                  older;
  logic [CMP_W-1:0]      img_maj, img_min, img_pat;
  logic [CMP_W-1:0]      run_maj, run_min, run_pat;

  assign c        = item.data_byte;
  assign base     = item.restart ? scan_state_t'('0) : st;
  assign first    = (base.count == '0);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign complete = !base.bad && (base.part_idx == 2'd2) && base.digit_seen;
  assign cur_part = base.parts[base.part_idx];
  assign prod     = (PROD_W'(cur_part) << 3) + (PROD_W'(cur_part) << 1)
                  + PROD_W'(c - CH_ZERO);
  assign sat_part = (prod > PROD_W'(PART_MAX)) ? PART_MAX : prod[PART_BITS-1:0];

  always_comb begin
    st_next = base;
    if (!base.found) begin
      if (base.capturing) begin
        if (c == CH_SEMI || base.count >= COUNT_W'(CAPTURE_BYTES - 1)) begin
          st_next.capturing = 1'b0;
          st_next.found     = 1'b1;
        end else begin
          st_next.count = base.count + 1'b1;
          if (first && (c == CH_LO_V || c == CH_UP_V)) begin
            st_next.count = base.count + 1'b1;
          end else if (base.bad || base.stopped) begin
            st_next.count = base.count + 1'b1;
          end else if (is_digit) begin
            st_next.parts[base.part_idx] = sat_part;
            st_next.digit_seen           = 1'b1;
          end else if (c == CH_DOT && base.digit_seen && base.part_idx < 2'd2) begin
            st_next.part_idx   = base.part_idx + 1'b1;
            st_next.digit_seen = 1'b0;
          end else if (complete) begin
            st_next.stopped = 1'b1;
          end else begin
            st_next.bad = 1'b1;
          end
        end
      end else if (c == tag_char(base.tag)) begin
        if (base.tag == TAG_W'(TAG_LEN - 1)) begin
          st_next.tag       = '0;
          st_next.capturing = 1'b1;
        end else begin
          st_next.tag = base.tag + 1'b1;
        end
      end else begin
        st_next.tag = (c == tag_char('0)) ? TAG_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // result, taken from the updated state
  assign complete_next = !st_next.bad && (st_next.part_idx == 2'd2) && st_next.digit_seen;
  assign valid   = st_next.found && complete_next;
  assign img_maj = CMP_W'(st_next.parts[0]);
  assign img_min = CMP_W'(st_next.parts[1]);
  assign img_pat = CMP_W'(st_next.parts[2]);
  assign run_maj = CMP_W'(run.major);
  assign run_min = CMP_W'(run.minor);
  assign run_pat = CMP_W'(run.patch);

  always_comb begin
    older = 1'b0;
    if (valid) begin
      if (run_maj != img_maj) begin
        older = run_maj > img_maj;
      end else if (run_min != img_min) begin
        older = run_min > img_min;
      end else begin
        older = run_pat > img_pat;
      end
    end
  end

  always_comb begin
    res.marker_found  = st_next.found;
    res.version_valid = valid;
    res.image_older   = older;
    res.image_major   = valid ? img_maj[15:0] : '0;
    res.image_minor   = valid ? img_min[15:0] : '0;
    res.image_patch   = valid ? img_pat[15:0] : '0;
    res.verdict_ready = item.image_end;
  end

  a_found_not_capturing: assert property (@(posedge clk) disable iff (rst)
    !(st.found && st.capturing))
    else $error("capture still open after marker finished");

  a_tag_idle_in_capture: assert property (@(posedge clk) disable iff (rst)
    (st.capturing || st.found) |-> (st.tag == '0))
    else $error("marker match advanced during capture");

  a_found_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && st.found && !item.restart) |=> st.found)
    else $error("found flag dropped without restart");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(st.count) && $stable(st.found) && $stable(st.tag)))
    else $error("scanner state moved without a byte");

  a_part_idx_range: assert property (@(posedge clk) disable iff (rst)
    st.part_idx != 2'd3)
    else $error("version part index out of range");

endmodule

// File: rtl/image_version_marker_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_version_marker_scanner
// Scans image bytes for the version marker, parses the version text and
// compares it with the running version held in APB registers.
// ----------------------------------------------------------------------------
// One byte transfer is taken every cycle while byte_ready is high, and every
// byte gives one result transfer. The byte is held in the input register,
// then the marker/parse update and the version compare go into the result
// register, from which its result transfer is made. While a result waits on
// result_ready the input register still takes one byte; after that
// byte_ready stays low until the waiting result is taken, and full rate
// resumes as soon as the sink takes results again. Configuration writes
// complete in the APB access cycle and apply to bytes processed afterwards.
module image_version_marker_scanner
  import ivms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  ivms_in_t           byte_data,
  output logic               result_valid,
  input  logic               result_ready,
  output ivms_out_t          result_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  ivms_in_t  in_q;
  logic      in_full;
  logic      advance;
  ivms_run_t run;
  ivms_out_t res;

  assign advance    = in_full && (!result_valid || result_ready);
  assign byte_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_q <= byte_data;
    end
    if (advance) begin
      result_data <= res;
    end
  end

  ivms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .run     (run)
  );

  ivms_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_q),
    .run  (run),
    .res  (res)
  );

endmodule

// File: tb/image_version_marker_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_version_marker_scanner_test
// Self-checking bench for the version marker scanner. A directed table walks
// the marker, a saturating version string and the first-marker-only rule,
// then four phases of random images run with different running versions and
// handshake idling. Every result transfer is checked field by field against a
// directed row's own expected value or else an in-bench scanner model.
// ----------------------------------------------------------------------------
module image_version_marker_scanner_test;
  import ivms_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 24;

  localparam logic [TAG_LEN-1:0][7:0] MARK_CHARS =
    {8'h3A, 8'h52, 8'h45, 8'h56, 8'h57, 8'h51, 8'h53};

  localparam ivms_out_t NONE_SEEN     = '0;
  localparam ivms_out_t NONE_SEEN_END = '{marker_found: 1'b0, version_valid: 1'b0,
                                          image_older: 1'b0, image_major: 16'h0000,
                                          image_minor: 16'h0000, image_patch: 16'h0000,
                                          verdict_ready: 1'b1};
  localparam ivms_out_t SAT_FOUND     = '{marker_found: 1'b1, version_valid: 1'b1,
                                          image_older: 1'b0, image_major: 16'hFFFF,
                                          image_minor: 16'h0000, image_patch: 16'h0007,
                                          verdict_ready: 1'b0};
  localparam ivms_out_t SAT_FOUND_END = '{marker_found: 1'b1, version_valid: 1'b1,
                                          image_older: 1'b0, image_major: 16'hFFFF,
                                          image_minor: 16'h0000, image_patch: 16'h0007,
                                          verdict_ready: 1'b1};

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       image_end;
    logic       typed;
    ivms_out_t  want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               byte_valid;
  logic               byte_ready;
  ivms_in_t           byte_data;
  logic               result_valid;
  logic               result_ready;
  ivms_out_t          result_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  image_version_marker_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // scanner model state
  int              mark_pos     = 0;
  bit              in_capture   = 1'b0;
  bit              capture_done = 1'b0;
  int              cap_len      = 0;
  int              part_sel     = 0;
  bit              have_digit   = 1'b0;
  bit              text_bad     = 1'b0;
  bit              text_stopped = 1'b0;
  longint unsigned part_val [3] = '{0, 0, 0};
  ivms_run_t       running_ver  = '0;

  ivms_out_t verdict_q [$];
  ivms_in_t  image_bytes [$];
  dir_row_t  directed_rows [DIR_ROWS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;
  int mismatches     = 0;
  int cycle_count    = 0;

  function automatic bit text_complete();
    return !text_bad && part_sel == 2 && have_digit;
  endfunction

  task automatic predict_verdict(input ivms_in_t b, output ivms_out_t r);
    longint unsigned part_max;
    longint unsigned acc;
    longint unsigned run_arr [3];
    logic [7:0]      c;
    bit              valid;
    bit              older;
    bit              decided;
    part_max = (64'd1 << PART_BITS) - 1;
    c = b.data_byte;
    if (b.restart) begin
      mark_pos     = 0;
      in_capture   = 1'b0;
      capture_done = 1'b0;
      cap_len      = 0;
      part_sel     = 0;
      have_digit   = 1'b0;
      text_bad     = 1'b0;
      text_stopped = 1'b0;
      part_val     = '{0, 0, 0};
    end
    if (!capture_done) begin
      if (in_capture) begin
        if (c == CH_SEMI || cap_len >= CAPTURE_BYTES - 1) begin
          in_capture   = 1'b0;
          capture_done = 1'b1;
        end else begin
          if (cap_len == 0 && (c == CH_LO_V || c == CH_UP_V)) begin
            // optional prefix, skipped
          end else if (!text_bad && !text_stopped) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
              acc = part_val[part_sel] * 10 + (c - CH_ZERO);
              if (acc > part_max) acc = part_max;
              part_val[part_sel] = acc;
              have_digit = 1'b1;
            end else if (c == CH_DOT && have_digit && part_sel < 2) begin
              part_sel++;
              have_digit = 1'b0;
            end else if (text_complete()) begin
              text_stopped = 1'b1;
            end else begin
              text_bad = 1'b1;
            end
          end
          cap_len++;
        end
      end else if (c == MARK_CHARS[mark_pos]) begin
        if (mark_pos == TAG_LEN - 1) begin
          mark_pos   = 0;
          in_capture = 1'b1;
        end else begin
          mark_pos++;
        end
      end else begin
        mark_pos = (c == MARK_CHARS[0]) ? 1 : 0;
      end
    end

    valid   = capture_done && text_complete();
    older   = 1'b0;
    decided = 1'b0;
    run_arr = '{running_ver.major, running_ver.minor, running_ver.patch};
    for (int i = 0; i < 3; i++) begin
      if (valid && !decided && run_arr[i] != part_val[i]) begin
        older   = run_arr[i] > part_val[i];
        decided = 1'b1;
      end
    end

    r.marker_found  = capture_done;
    r.version_valid = valid;
    r.image_older   = older;
    r.image_major   = valid ? part_val[0][15:0] : 16'h0000;
    r.image_minor   = valid ? part_val[1][15:0] : 16'h0000;
    r.image_patch   = valid ? part_val[2][15:0] : 16'h0000;
    r.verdict_ready = b.image_end;
  endtask

  task automatic send_byte(input ivms_in_t b, input bit use_typed, input ivms_out_t typed_want);
    ivms_out_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    byte_data  <= b;
    do @(posedge clk); while (!byte_ready);
    predict_verdict(b, want);
    verdict_q.push_back(use_typed ? typed_want : want);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] c);
    image_bytes.push_back('{data_byte: c, restart: 1'b0, image_end: 1'b0});
  endtask

  task automatic add_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_SEMI);
    add_byte(c);
  endtask

  task automatic add_marker();
    for (int j = 0; j < TAG_LEN; j++) add_byte(MARK_CHARS[j]);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input ivms_run_t cfg,
                           input bit long_hold);
    int    sent;
    int    k;
    string digits;
    wait_drained();
    write_reg(REG_MAJOR, cfg.major);
    write_reg(REG_MINOR, cfg.minor);
    write_reg(REG_PATCH, cfg.patch);
    running_ver    = cfg;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_pending = 1'b1;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      image_bytes.delete();
      repeat ($urandom_range(6)) add_byte(8'($urandom_range(255)));
      if ($urandom_range(2) == 0) begin
        k = $urandom_range(1, TAG_LEN - 1);
        for (int j = 0; j < k; j++) add_byte(MARK_CHARS[j]);
        add_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(9) != 0) begin
        add_marker();
        if ($urandom_range(15) != 0) begin
          case ($urandom_range(3))
            0:       add_byte(CH_LO_V);
            1:       add_byte(CH_UP_V);
            default: ;
          endcase
          for (int p = 0; p < 3; p++) begin
            case ($urandom_range(7))
              0:       digits = "";
              5:       digits = $sformatf("%0d", $urandom_range(99999));
              6:       digits = $sformatf("%0d", $urandom);
              7:       digits = $sformatf("%0d", $urandom_range(65530, 65540));
              default: digits = $sformatf("%0d", $urandom_range(3));
            endcase
            for (int j = 0; j < digits.len(); j++) add_byte(digits[j]);
            if (p < 2) begin
              case ($urandom_range(11))
                0:       add_junk();
                1:       ;
                default: add_byte(CH_DOT);
              endcase
            end
          end
          if ($urandom_range(2) == 0) repeat ($urandom_range(1, 4)) add_junk();
        end
        if ($urandom_range(3) != 0) add_byte(CH_SEMI);
        else repeat (CAPTURE_BYTES) add_junk();
      end
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
      if ($urandom_range(3) == 0) begin
        // later marker must be ignored
        add_marker();
        add_byte(CH_NINE);
        add_byte(CH_SEMI);
      end
      foreach (image_bytes[i]) begin
        if ($urandom_range(39) == 0) image_bytes[i].restart = 1'b1;
        if ($urandom_range(39) == 0) image_bytes[i].image_end = 1'b1;
      end
      image_bytes[0].restart = 1'b1;
      image_bytes[image_bytes.size() - 1].image_end = 1'b1;
      foreach (image_bytes[i]) send_byte(image_bytes[i], 1'b0, NONE_SEEN);
      sent += image_bytes.size();
    end
    byte_valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    ivms_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no verdict pending");
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("marker_found", 16'(want.marker_found),
                    16'(result_data.marker_found));
        check_field("version_valid", 16'(want.version_valid),
                    16'(result_data.version_valid));
        check_field("image_older", 16'(want.image_older),
                    16'(result_data.image_older));
        check_field("image_major", want.image_major, result_data.image_major);
        check_field("image_minor", want.image_minor, result_data.image_minor);
        check_field("image_patch", want.image_patch, result_data.image_patch);
        check_field("verdict_ready", 16'(want.verdict_ready),
                    16'(result_data.verdict_ready));
      end
    end
  end

  initial begin : result_sink
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main_seq
    ivms_in_t b;
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_data  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    directed_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b1, NONE_SEEN},
      '{8'hFF, 1'b0, 1'b1, 1'b1, NONE_SEEN_END},
      '{8'h53, 1'b1, 1'b0, 1'b0, NONE_SEEN},
      '{8'h53, 1'b0, 1'b0, 1'b0, NONE_SEEN},     // repeated first char restarts at one
      '{8'h51, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h57, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h56, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h45, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h52, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h3A, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h56, 1'b0, 1'b0, 1'b0, NONE_SEEN},     // upper-case prefix
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h39, 1'b0, 1'b0, 1'b0, NONE_SEEN},     // major saturates
      '{8'h2E, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h30, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h2E, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h37, 1'b0, 1'b0, 1'b0, NONE_SEEN},
      '{8'h78, 1'b0, 1'b0, 1'b0, NONE_SEEN},     // trailing text stops parse
      '{8'h3B, 1'b0, 1'b0, 1'b1, SAT_FOUND},
      '{8'h53, 1'b0, 1'b1, 1'b1, SAT_FOUND_END}, // state held past image end
      '{8'h3A, 1'b1, 1'b1, 1'b1, NONE_SEEN_END}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      b = '{data_byte: directed_rows[i].data, restart: directed_rows[i].restart,
            image_end: directed_rows[i].image_end};
      send_byte(b, directed_rows[i].typed, directed_rows[i].want);
    end
    byte_valid <= 1'b0;

    run_phase(0,  0,  '{major: 16'd0,     minor: 16'd0,     patch: 16'd0},     1'b1);
    run_phase(51, 0,  '{major: 16'd1,     minor: 16'd2,     patch: 16'd3},     1'b0);
    run_phase(0,  51, '{major: 16'hFFFF,  minor: 16'hFFFF,  patch: 16'hFFFF},  1'b0);
    run_phase(30, 30, '{major: 16'd2,     minor: 16'd1,     patch: 16'd0},     1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
